>>> rtl/vca_pkg.sv
package vca_pkg;

    localparam int KIND_W     = 2;
    localparam int PRIO_W     = 8;
    localparam int HANDLE_W   = 25;
    localparam int GEN_W      = 17;
    localparam int HIDX_W     = 8;
    localparam int CHIDX_W    = 5;
    localparam int CNT_W      = 6;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [GEN_W-1:0] GEN_LIMIT     = 17'h0FFFF;
    localparam logic [GEN_W-1:0] GEN_RESTART   = 17'd1;
    localparam logic [CNT_W-1:0] ACTIVE_RESET  = 6'd32;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [PRIO_W-1:0]   request_priority;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [CHIDX_W-1:0]  channel_index;
        logic [HANDLE_W-1:0] handle_out;
        logic                stolen;
    } rsp_t;

    // One channel table entry as held in memory.
    typedef struct packed {
        logic              occ;
        logic [PRIO_W-1:0] prio;
        logic [GEN_W-1:0]  gen;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Control between the sequencer and the top level.
    typedef struct packed {
        logic busy;
        logic res_valid;
    } ctrl_status_t;

endpackage

>>> rtl/vca_ram.sv
module vca_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/vca_ctrl.sv
module vca_ctrl #(
    parameter int MAX_CHANNELS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  vca_pkg::req_t             item,
    input  logic                      item_accept,
    input  logic [vca_pkg::CNT_W-1:0] live_count,
    input  logic                      res_take,
    output vca_pkg::rsp_t             res,
    output vca_pkg::ctrl_status_t     status
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ENT_W = $bits(vca_pkg::entry_t);

    vca_pkg::state_t state_reg, state_next;
    vca_pkg::req_t   item_reg, item_next;
    vca_pkg::rsp_t   res_reg, res_next;

    logic [vca_pkg::CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [vca_pkg::CNT_W-1:0]  proc_reg, proc_next;
    logic                       pend_reg, pend_next;
    logic [vca_pkg::PRIO_W-1:0] bound_reg, bound_next;
    logic [vca_pkg::CNT_W-1:0]  pick_reg, pick_next;
    logic [vca_pkg::GEN_W-1:0]  pgen_reg, pgen_next;
    logic                       evict_reg, evict_next;
    logic                       found_reg, found_next;
    logic [MAX_CHANNELS-1:0]    vld_reg, vld_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    vca_pkg::entry_t             ent;
    vca_pkg::entry_t             wr_ent;
    logic                        ent_vld;
    logic                        ent_occ;
    logic [vca_pkg::GEN_W-1:0]   ent_gen;
    logic [vca_pkg::HIDX_W-1:0]  in_hidx;
    logic                        in_hidx_ok;
    logic [vca_pkg::HIDX_W-1:0]  hidx;
    logic [vca_pkg::GEN_W-1:0]   hgen;
    logic                        scan_last;
    logic                        scan_take;
    logic                        scan_issue;
    logic                        hit;
    logic [vca_pkg::GEN_W-1:0]   gen_bump;
    logic [vca_pkg::CNT_W-1:0]   ent_idx;

    vca_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_hidx    = item.handle_in[vca_pkg::HIDX_W-1:0];
    assign in_hidx_ok = in_hidx < {2'b00, live_count};
    assign hidx       = item_reg.handle_in[vca_pkg::HIDX_W-1:0];
    assign hgen       = item_reg.handle_in[vca_pkg::HANDLE_W-1:vca_pkg::HIDX_W];

    // Entry under examination: scan position or handle index.
    assign ent_idx = (state_reg == vca_pkg::ST_CHECK) ? vca_pkg::CNT_W'(hidx) : proc_reg;
    assign ent     = vca_pkg::entry_t'(ram_rdata);
    assign ent_vld = vld_reg[IDX_W'(ent_idx)];
    assign ent_occ = ent_vld & ent.occ;
    assign ent_gen = ent_vld ? ent.gen : '0;

    assign scan_last  = proc_reg == (live_count - 6'd1);
    assign scan_take  = ent_occ && (bound_reg >= ent.prio);
    assign scan_issue = rd_cnt_reg < live_count;
    assign hit        = ent_occ && (ent_gen == hgen);

    // Count past the limit restarts at one so a fresh handle never has generation zero.
    assign gen_bump = (pgen_reg > vca_pkg::GEN_LIMIT) ? vca_pkg::GEN_RESTART
                                                      : pgen_reg + 17'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vca_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    priority if (item.kind == vca_pkg::KIND_ALLOC)
                        state_next = (live_count == '0) ? vca_pkg::ST_DONE : vca_pkg::ST_SCAN;
                    else if (item.kind == vca_pkg::KIND_LOOKUP ||
                             item.kind == vca_pkg::KIND_RELEASE)
                        state_next = in_hidx_ok ? vca_pkg::ST_CHECK : vca_pkg::ST_DONE;
                    else
                        state_next = vca_pkg::ST_DONE;
                end
            end
            vca_pkg::ST_SCAN:
            begin
                if (pend_reg)
                begin
                    priority if (!ent_occ)
                        state_next = vca_pkg::ST_WRITE;
                    else if (scan_last)
                        state_next = (found_reg || scan_take) ? vca_pkg::ST_WRITE
                                                              : vca_pkg::ST_DONE;
                    else
                        state_next = vca_pkg::ST_SCAN;
                end
            end
            vca_pkg::ST_CHECK: state_next = vca_pkg::ST_DONE;
            vca_pkg::ST_WRITE: state_next = vca_pkg::ST_DONE;
            vca_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = vca_pkg::ST_IDLE;
                end
            end
            default: state_next = vca_pkg::ST_IDLE;
        endcase
    end

    // Outputs: memory port and status
    always_comb
    begin
        ram_re           = 1'b0;
        ram_raddr        = '0;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        wr_ent           = ent;
        status.busy      = 1'b1;
        status.res_valid = 1'b0;
        unique case (state_reg)
            vca_pkg::ST_IDLE:
            begin
                status.busy = 1'b0;
                // Launch the first read together with the accept.
                ram_re      = item_accept;
                ram_raddr   = (item.kind == vca_pkg::KIND_ALLOC) ? '0 : IDX_W'(in_hidx);
            end
            vca_pkg::ST_SCAN:
            begin
                ram_re    = scan_issue;
                ram_raddr = IDX_W'(rd_cnt_reg);
            end
            vca_pkg::ST_CHECK:
            begin
                ram_we     = hit && (item_reg.kind == vca_pkg::KIND_RELEASE);
                ram_waddr  = IDX_W'(hidx);
                wr_ent.occ = 1'b0;
            end
            vca_pkg::ST_WRITE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = IDX_W'(pick_reg);
                wr_ent.occ  = 1'b1;
                wr_ent.prio = item_reg.request_priority;
                wr_ent.gen  = gen_bump;
            end
            vca_pkg::ST_DONE:
            begin
                status.res_valid = 1'b1;
            end
            default:
            begin
                status.busy = 1'b1;
            end
        endcase
    end

    assign ram_wdata = ENT_W'(wr_ent);

    // Datapath
    always_comb
    begin
        item_next   = item_reg;
        res_next    = res_reg;
        rd_cnt_next = rd_cnt_reg;
        proc_next   = proc_reg;
        pend_next   = pend_reg;
        bound_next  = bound_reg;
        pick_next   = pick_reg;
        pgen_next   = pgen_reg;
        evict_next  = evict_reg;
        found_next  = found_reg;
        vld_next    = vld_reg;
        unique case (state_reg)
            vca_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    item_next   = item;
                    res_next    = '0;
                    rd_cnt_next = 6'd1;
                    proc_next   = '0;
                    pend_next   = 1'b1;
                    bound_next  = item.request_priority;
                    found_next  = 1'b0;
                    evict_next  = 1'b0;
                end
            end
            vca_pkg::ST_SCAN:
            begin
                pend_next = scan_issue;
                if (scan_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 6'd1;
                    proc_next   = rd_cnt_reg;
                end
                if (pend_reg)
                begin
                    priority if (!ent_occ)
                    begin
                        pick_next  = proc_reg;
                        pgen_next  = ent_gen;
                        evict_next = 1'b0;
                        found_next = 1'b1;
                    end
                    else if (scan_take)
                    begin
                        bound_next = ent.prio;
                        pick_next  = proc_reg;
                        pgen_next  = ent_gen;
                        evict_next = 1'b1;
                        found_next = 1'b1;
                    end
                end
            end
            vca_pkg::ST_CHECK:
            begin
                if (hit)
                begin
                    res_next.ok            = 1'b1;
                    res_next.channel_index = hidx[vca_pkg::CHIDX_W-1:0];
                end
            end
            vca_pkg::ST_WRITE:
            begin
                vld_next[IDX_W'(pick_reg)] = 1'b1;
                res_next.ok            = 1'b1;
                res_next.channel_index = pick_reg[vca_pkg::CHIDX_W-1:0];
                res_next.handle_out    = {gen_bump, 2'b00, pick_reg};
                res_next.stolen        = evict_reg;
            end
            vca_pkg::ST_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vca_pkg::ST_IDLE;
            vld_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        rd_cnt_reg <= rd_cnt_next;
        proc_reg   <= proc_next;
        bound_reg  <= bound_next;
        pick_reg   <= pick_next;
        pgen_reg   <= pgen_next;
        evict_reg  <= evict_next;
    end

    assign res = res_reg;

endmodule

>>> rtl/voice_channel_allocator_unit.sv
// Voice channel allocator. The channel table (occupied mark, priority,
// generation) lives in one single-port-read RAM; an allocate walks the active
// channels one RAM read per cycle and stops at the first empty one; if none is
// empty it evicts the channel of lowest priority not above the request's (on a
// tie the later one), else it fails. A lookup or release reads one entry. One
// item is in work at a time: req_stall is high from the accept until the result
// moves into the output register, and a result waiting there does not hold off
// the next item. cfg_data sets the number of active channels (reset 32, capped
// at MAX_CHANNELS); write it only while no item is in work. cfg_ready is always
// high.
module voice_channel_allocator_unit #(
    parameter int MAX_CHANNELS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  vca_pkg::req_t             req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output vca_pkg::rsp_t             rsp_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [vca_pkg::CNT_W-1:0] cfg_data
);

    logic [vca_pkg::CNT_W-1:0] active_reg;
    logic [vca_pkg::CNT_W-1:0] live_count;
    logic                      rsp_valid_reg;
    vca_pkg::rsp_t             rsp_data_reg;
    vca_pkg::rsp_t             res;
    vca_pkg::ctrl_status_t     status;
    logic                      item_accept;
    logic                      res_take;

    assign cfg_ready   = 1'b1;
    assign req_stall   = status.busy;
    assign item_accept = req_valid && !status.busy;
    assign res_take    = status.res_valid && (!rsp_valid_reg || !rsp_stall);

    assign live_count = ({3'b000, active_reg} > 9'(MAX_CHANNELS))
                      ? vca_pkg::CNT_W'(MAX_CHANNELS) : active_reg;

    vca_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (req_data),
        .item_accept (item_accept),
        .live_count  (live_count),
        .res_take    (res_take),
        .res         (res),
        .status      (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= vca_pkg::ACTIVE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                active_reg <= cfg_data;
            end
            if (res_take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("accepted item did not raise stall");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.ok |-> rsp_data.channel_index == '0 &&
            rsp_data.handle_out == '0 && !rsp_data.stolen)
        else $error("failed result carries nonzero fields");

    a_stolen_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.stolen |-> rsp_data.ok)
        else $error("eviction reported without success");

    a_handle_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.handle_out != '0 |->
            rsp_data.handle_out[vca_pkg::HANDLE_W-1:vca_pkg::HIDX_W] != '0)
        else $error("new handle has generation zero");

endmodule
